FILE: rtl/core/arot_pkg.sv
package arot_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int COORD_FRAC_BITS = 16;
  localparam int ATAN_ENTRIES    = 30;
  localparam int STAGE_W         = $clog2(ATAN_ENTRIES);

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // CORDIC gain 0.6072529350 in Q2.30
  localparam logic signed [31:0] GAIN_Q30  = 32'sh26DD3B6A;
  localparam logic [31:0]        HALF_TURN = 32'h8000_0000;
  localparam logic signed [32:0] ONE_Z     = 33'sd1 <<< COORD_FRAC_BITS;
  localparam logic signed [65:0] ROUND_Q30 = 66'sd1 <<< 29;

  localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // Point payload that rides along the rotator
  typedef struct packed {
    logic              cmd;
    logic [1:0]        axis;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] zp;   // z, minus one unit for pivot mode
    logic              flip;  // negate cos and sin at the end
  } arot_pt_t;

  // CORDIC vector and residual angle
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] res;
  } arot_rot_t;

  function automatic logic [31:0] atan_val(input logic [STAGE_W-1:0] idx);
    logic [31:0] v;
    v = 32'h0;
    if (32'(idx) < 32'(ATAN_ENTRIES)) begin
      v = ATAN_TABLE[idx];
    end
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if ((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111)) begin
      r = v[31:0];
    end else if (v[36]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/arot_cell.sv
module arot_cell import arot_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [STAGE_W-1:0] stage_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  arot_rot_t          rot_i,
  input  arot_pt_t           pt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output arot_rot_t          rot_o,
  output arot_pt_t           pt_o
);

  logic      valid_q, valid_d;
  arot_rot_t rot_q, rot_d;
  arot_pt_t  pt_q;
  logic      load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_comb begin
    logic signed [31:0] cx, cy, res, dx, dy, ang;
    cx  = rot_i.cx;
    cy  = rot_i.cy;
    res = rot_i.res;
    dx  = cy >>> stage_i;
    dy  = cx >>> stage_i;
    ang = signed'(atan_val(stage_i));
    // steer toward zero residual
    if (!res[31]) begin
      rot_d.cx  = cx - dx;
      rot_d.cy  = cy + dy;
      rot_d.res = res - ang;
    end else begin
      rot_d.cx  = cx + dx;
      rot_d.cy  = cy - dy;
      rot_d.res = res + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rot_q <= rot_d;
      pt_q  <= pt_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rot_o       = rot_q;
  assign pt_o        = pt_q;

  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(rot_q) && $stable(pt_q)))
    else $error("cell lost or changed a held word");

endmodule

FILE: rtl/core/arot_mix.sv
module arot_mix import arot_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  arot_rot_t   rot_i,
  input  arot_pt_t    pt_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o
);

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;

  // stage 1: four products
  arot_pt_t           pt1_q;
  logic signed [64:0] p_ac_q, p_bs_q, p_as_q, p_bc_q;
  logic signed [64:0] p_ac_d, p_bs_d, p_as_d, p_bc_d;

  // stage 2: sums, rounded back to coordinate scale
  arot_pt_t           pt2_q;
  logic signed [35:0] rm_q, rp_q, rm_d, rp_d;

  // stage 3: output word
  logic [31:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  logic [1:0]  axis3_q;
  logic        cmd3_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    logic signed [31:0] c, s;
    logic signed [32:0] a, b;
    c = pt_i.flip ? -rot_i.cx : rot_i.cx;
    s = pt_i.flip ? -rot_i.cy : rot_i.cy;
    unique case (pt_i.axis)
      AXIS_X: begin
        a = pt_i.zp;
        b = pt_i.zp;
        a = 33'(pt_i.y);
      end
      AXIS_Y: begin
        a = pt_i.zp;
        b = 33'(pt_i.x);
      end
      AXIS_Z: begin
        a = 33'(pt_i.x);
        b = 33'(pt_i.y);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
    p_ac_d = 65'(a) * 65'(c);
    p_bs_d = 65'(b) * 65'(s);
    p_as_d = 65'(a) * 65'(s);
    p_bc_d = 65'(b) * 65'(c);
  end

  always_comb begin
    logic signed [65:0] sm, sp;
    sm   = 66'(p_ac_q) - 66'(p_bs_q) + ROUND_Q30;
    sp   = 66'(p_as_q) + 66'(p_bc_q) + ROUND_Q30;
    rm_d = sm[65:30];
    rp_d = sp[65:30];
  end

  always_comb begin
    logic signed [36:0] rx, ry, rz, px, py, pz, mm, pp;
    px = 37'(pt2_q.x);
    py = 37'(pt2_q.y);
    pz = 37'(pt2_q.zp);
    mm = 37'(rm_q);
    pp = 37'(rp_q);
    unique case (pt2_q.axis)
      AXIS_X: begin
        rx = px;
        ry = mm;
        rz = pp;
      end
      AXIS_Y: begin
        rx = pp;
        ry = py;
        rz = mm;
      end
      AXIS_Z: begin
        rx = mm;
        ry = pp;
        rz = pz;
      end
      default: begin
        rx = '0;
        ry = '0;
        rz = '0;
      end
    endcase
    // move back off the pivot
    if (pt2_q.cmd) begin
      rz = rz + 37'(ONE_Z);
    end
    ox_d = sat32(rx);
    oy_d = sat32(ry);
    oz_d = sat32(rz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      pt1_q  <= pt_i;
      p_ac_q <= p_ac_d;
      p_bs_q <= p_bs_d;
      p_as_q <= p_as_d;
      p_bc_q <= p_bc_d;
    end
    if (rdy2 && v1_q) begin
      pt2_q <= pt1_q;
      rm_q  <= rm_d;
      rp_q  <= rp_d;
    end
    if (rdy3 && v2_q) begin
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      oz_q    <= oz_d;
      axis3_q <= pt2_q.axis;
      cmd3_q  <= pt2_q.cmd;
    end
  end

  assign out_valid_o = v3_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (axis3_q == AXIS_NONE)) |-> ((ox_q == '0) && (oy_q == '0)))
    else $error("axis none gave a nonzero x or y");

  a_none_pivot_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (axis3_q == AXIS_NONE)) |->
      (oz_q == (cmd3_q ? 32'(ONE_Z) : 32'h0)))
    else $error("axis none gave a wrong z");

  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(p_ac_q) && $stable(p_bc_q)))
    else $error("product stage dropped a held word");

endmodule

FILE: rtl/core/axis_rotation_3d.sv
// Rotates a Q16.16 point about the X, Y or Z axis (or about the pivot (0,0,1)
// when cmd_i is set) by a 16-bit binary angle, one point per cycle unless
// out_ready_i stalls the output. A point enters a row of CORDIC_STAGES cells,
// each doing one CORDIC micro-rotation to form cos and sin, then three stages
// (products, rounded sums, pivot add and saturation) produce the result. Each
// stage parts with its word as soon as the next can take it, so bubbles close
// up and a stalled output blocks input only once every stage holds a word.
// Axis code 3 returns zero (z of one unit in pivot mode).
module axis_rotation_3d import arot_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [1:0]  axis_i,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [31:0] in_z_i,
  input  logic [15:0] angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o
);

  logic      valid_c [CORDIC_STAGES+1];
  logic      ready_c [CORDIC_STAGES+1];
  arot_rot_t rot_c   [CORDIC_STAGES+1];
  arot_pt_t  pt_c    [CORDIC_STAGES+1];

  // fold the angle into [-90, 90) degrees; the flip restores the sign later
  always_comb begin
    logic [31:0] full;
    logic        flip;
    full = {angle_i, 16'h0};
    flip = (angle_i[15:14] == 2'b01) || (angle_i[15:14] == 2'b10);
    rot_c[0].cx  = GAIN_Q30;
    rot_c[0].cy  = '0;
    rot_c[0].res = signed'(flip ? (full ^ HALF_TURN) : full);
    pt_c[0].cmd  = cmd_i;
    pt_c[0].axis = axis_i;
    pt_c[0].x    = signed'(in_x_i);
    pt_c[0].y    = signed'(in_y_i);
    pt_c[0].zp   = 33'(signed'(in_z_i)) - (cmd_i ? ONE_Z : 33'sd0);
    pt_c[0].flip = flip;
  end

  assign valid_c[0] = in_valid_i;
  assign in_ready_o = ready_c[0];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    arot_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stage_i    (STAGE_W'(g)),
      .in_valid_i (valid_c[g]),
      .in_ready_o (ready_c[g]),
      .rot_i      (rot_c[g]),
      .pt_i       (pt_c[g]),
      .out_valid_o(valid_c[g+1]),
      .out_ready_i(ready_c[g+1]),
      .rot_o      (rot_c[g+1]),
      .pt_o       (pt_c[g+1])
    );
  end

  arot_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (valid_c[CORDIC_STAGES]),
    .in_ready_o (ready_c[CORDIC_STAGES]),
    .rot_i      (rot_c[CORDIC_STAGES]),
    .pt_i       (pt_c[CORDIC_STAGES]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o)
  );

endmodule
